// ===== hdl/bsfc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsfc_pkg: shared definitions for the burst squelch frame capture block
// Register indexes, field widths, reset values and the flag bundle passed
// from the noise floor tracker to the capture control.
// ----------------------------------------------------------------------------
package bsfc_pkg;

  // Defaults for the top level parameters.
  localparam int unsigned MAX_CAPTURE_DEF = 262144;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // Configuration port.
  localparam int unsigned CFG_W     = 19;
  localparam int unsigned CFG_IDX_W = 3;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SPS       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BODY_LEN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ON_FLOOR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_FLOOR = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = 3'd6;

  // Register widths.
  localparam int unsigned SPS_W   = 13;
  localparam int unsigned LEN_W   = 19;
  localparam int unsigned FLOOR_W = 15;
  localparam int unsigned ALPHA_W = 16;

  // Register reset values.
  localparam logic [SPS_W-1:0]   SPS_RST       = 13'd48;
  localparam logic [LEN_W-1:0]   BODY_LEN_RST  = 19'd4800;
  localparam logic [LEN_W-1:0]   FRAME_LEN_RST = 19'd7392;
  localparam logic [LEN_W-1:0]   CAPACITY_RST  = 19'd7440;
  localparam logic [FLOOR_W-1:0] ON_FLOOR_RST  = 15'd655;
  localparam logic [FLOOR_W-1:0] OFF_FLOOR_RST = 15'd328;
  localparam logic [ALPHA_W-1:0] ALPHA_RST     = 16'd66;

  // Fixed point scale of the noise floor and threshold multipliers.
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned ON_MULT   = 6;
  localparam int unsigned OFF_MULT  = 3;

  // Silence detection.
  localparam int unsigned              QUIET_W         = 14;
  localparam logic [QUIET_W-1:0]       QUIET_MAX       = 14'd16383;
  localparam int unsigned              SIL_W           = 15;
  localparam int unsigned              SILENCE_SYMBOLS = 3;

  // Per-sample decisions from the floor tracker.
  typedef struct packed {
    logic trigger;
    logic quiet;
  } floor_flags_t;

endpackage : bsfc_pkg
`default_nettype wire

// ===== hdl/bsfc_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsfc_in_if: sample input channel
// Valid/ready channel carrying one signed audio sample per beat.
// ----------------------------------------------------------------------------
interface bsfc_in_if #(
  parameter int unsigned SAMPLE_BITS = bsfc_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface : bsfc_in_if
`default_nettype wire

// ===== hdl/bsfc_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsfc_out_if: capture result channel
// Valid/ready channel carrying one capture result per beat.
// ----------------------------------------------------------------------------
interface bsfc_out_if #(
  parameter int unsigned SAMPLE_BITS = bsfc_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned MAX_CAPTURE = bsfc_pkg::MAX_CAPTURE_DEF
);
  localparam int unsigned IDX_W = $clog2(MAX_CAPTURE);
  localparam int unsigned CNT_W = $clog2(MAX_CAPTURE + 1);

  logic                          valid;
  logic                          ready;
  logic                          store_valid;
  logic [IDX_W-1:0]              store_index;
  logic signed [SAMPLE_BITS-1:0] stored_sample;
  logic                          frame_ready;
  logic [CNT_W-1:0]              frame_samples;
  logic                          collecting;

  modport source (
    output valid, output store_valid, output store_index, output stored_sample,
    output frame_ready, output frame_samples, output collecting, input ready
  );
  modport sink (
    input valid, input store_valid, input store_index, input stored_sample,
    input frame_ready, input frame_samples, input collecting, output ready
  );
endinterface : bsfc_out_if
`default_nettype wire

// ===== hdl/bsfc_floor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsfc_floor: adaptive noise floor tracker
// Compares a magnitude against the trigger and quiet thresholds derived from
// the current floor, and computes the smoothed floor for the next sample.
// ----------------------------------------------------------------------------
module bsfc_floor #(
  parameter int unsigned SAMPLE_BITS = bsfc_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned AX_W = SAMPLE_BITS - 1,
  localparam int unsigned NW   = AX_W + bsfc_pkg::FRAC_BITS
) (
  input  wire logic [AX_W-1:0]                ax_i,
  input  wire logic [NW-1:0]                  noise_i,
  input  wire logic [bsfc_pkg::ALPHA_W-1:0]   alpha_i,
  input  wire logic [bsfc_pkg::FLOOR_W-1:0]   on_floor_i,
  input  wire logic [bsfc_pkg::FLOOR_W-1:0]   off_floor_i,
  output      logic [NW-1:0]                  noise_o,
  output      bsfc_pkg::floor_flags_t         flags_o
);

  // Threshold compare width: room for 6x the floor and for a floor constant.
  localparam int unsigned TA = NW + 3;
  localparam int unsigned TB = bsfc_pkg::FLOOR_W + bsfc_pkg::FRAC_BITS;
  localparam int unsigned TW = (TA > TB) ? TA : TB;
  // Smoothing product widths.
  localparam int unsigned PW = NW + bsfc_pkg::ALPHA_W + 2;
  localparam int unsigned SW = PW - bsfc_pkg::FRAC_BITS;

  logic [NW-1:0]        axs;
  logic [TW-1:0]        axs_w;
  logic [TW-1:0]        on_noise;
  logic [TW-1:0]        on_min;
  logic [TW-1:0]        off_noise;
  logic [TW-1:0]        off_min;
  logic signed [NW:0]   diff;
  logic signed [PW-1:0] prod;
  logic signed [SW-1:0] step;
  logic signed [SW-1:0] sum;

  assign axs   = {ax_i, {bsfc_pkg::FRAC_BITS{1'b0}}};
  assign axs_w = TW'(axs);

  // Thresholds; a compare against max(a, b) splits into two compares.
  assign on_noise  = TW'(noise_i) * TW'(bsfc_pkg::ON_MULT);
  assign on_min    = TW'(on_floor_i) << bsfc_pkg::FRAC_BITS;
  assign off_noise = TW'(noise_i) * TW'(bsfc_pkg::OFF_MULT);
  assign off_min   = TW'(off_floor_i) << bsfc_pkg::FRAC_BITS;

  assign flags_o.trigger = (axs_w > on_noise) && (axs_w > on_min);
  assign flags_o.quiet   = (axs_w < off_noise) || (axs_w < off_min);

  // Floor update: the arithmetic shift rounds toward minus infinity.
  assign diff    = $signed({1'b0, axs}) - $signed({1'b0, noise_i});
  assign prod    = diff * $signed({1'b0, alpha_i});
  assign step    = prod[PW-1:bsfc_pkg::FRAC_BITS];
  assign sum     = $signed({2'b00, noise_i}) + step;
  assign noise_o = sum[NW-1:0];

endmodule : bsfc_floor
`default_nettype wire

// ===== hdl/burst_squelch_frame_capture.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// burst_squelch_frame_capture: squelch gated burst capture front end
// Tracks a noise floor, starts a capture on a loud sample and reports buffer
// writes and decode requests for each incoming sample.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on in_if, one beat per sample. Every sample yields exactly
//   one result beat on out_if: the buffer write (store_valid, store_index,
//   stored_sample), a decode request (frame_ready, frame_samples) and the
//   mode after the sample (collecting).
//   Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i while no
//   sample is in flight; writes take effect at once.
//   An accepted input beat passes through the input register, then through
//   the floor update and the capture control into the result register.
//   Throughput is one sample per cycle while the receiver keeps out_if.ready
//   high, set by the floor update loop (one multiply and add) that feeds
//   each sample's threshold decision from the previous sample's floor.
//   When the receiver stalls, the result register holds its beat and the
//   input register still takes one more sample; in_if.ready falls only when
//   both are full. Reset returns to searching with a zero floor and clears
//   both counters and the registers to their defaults.
// ----------------------------------------------------------------------------
module burst_squelch_frame_capture #(
  parameter int unsigned MAX_CAPTURE = bsfc_pkg::MAX_CAPTURE_DEF,
  parameter int unsigned SAMPLE_BITS = bsfc_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [bsfc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [bsfc_pkg::CFG_W-1:0]       cfg_data_i,
  bsfc_in_if.sink                               in_if,
  bsfc_out_if.source                            out_if
);

  localparam int unsigned AX_W  = SAMPLE_BITS - 1;
  localparam int unsigned NW    = AX_W + bsfc_pkg::FRAC_BITS;
  localparam int unsigned IDX_W = $clog2(MAX_CAPTURE);
  localparam int unsigned CNT_W = $clog2(MAX_CAPTURE + 1);
  localparam int unsigned CMP_W = (CNT_W > bsfc_pkg::CFG_W) ? CNT_W : bsfc_pkg::CFG_W;
  localparam int unsigned SIL_W = bsfc_pkg::SIL_W;

  // Configuration registers.
  logic [bsfc_pkg::SPS_W-1:0]   sps_q;
  logic [bsfc_pkg::LEN_W-1:0]   body_len_q;
  logic [bsfc_pkg::LEN_W-1:0]   frame_len_q;
  logic [bsfc_pkg::LEN_W-1:0]   capacity_q;
  logic [bsfc_pkg::FLOOR_W-1:0] on_floor_q;
  logic [bsfc_pkg::FLOOR_W-1:0] off_floor_q;
  logic [bsfc_pkg::ALPHA_W-1:0] alpha_q;

  // Input register.
  logic                          in_valid_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          advance;

  // Capture state.
  logic                          mode_q, mode_d;
  logic [NW-1:0]                 noise_q, noise_d;
  logic [CNT_W-1:0]              count_q, count_d;
  logic [bsfc_pkg::QUIET_W-1:0]  quiet_q, quiet_d;

  // Result register.
  logic                          out_valid_q;
  logic                          st_valid_q, st_valid_d;
  logic [IDX_W-1:0]              st_index_q, st_index_d;
  logic signed [SAMPLE_BITS-1:0] st_sample_q, st_sample_d;
  logic                          fr_ready_q, fr_ready_d;
  logic [CNT_W-1:0]              fr_samples_q, fr_samples_d;

  // Datapath signals.
  logic [SAMPLE_BITS-1:0]        mag_full;
  logic [AX_W-1:0]               ax;
  logic [NW-1:0]                 noise_upd;
  bsfc_pkg::floor_flags_t        flags;
  logic [CMP_W-1:0]              cap_raw;
  logic [CMP_W-1:0]              cap_eff;
  logic                          room;
  logic [CNT_W-1:0]              count_inc;
  logic [bsfc_pkg::QUIET_W-1:0]  quiet_inc;
  logic [SIL_W-1:0]              silence_lim;
  logic                          full_hit;
  logic                          silence_hit;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sps_q       <= bsfc_pkg::SPS_RST;
      body_len_q  <= bsfc_pkg::BODY_LEN_RST;
      frame_len_q <= bsfc_pkg::FRAME_LEN_RST;
      capacity_q  <= bsfc_pkg::CAPACITY_RST;
      on_floor_q  <= bsfc_pkg::ON_FLOOR_RST;
      off_floor_q <= bsfc_pkg::OFF_FLOOR_RST;
      alpha_q     <= bsfc_pkg::ALPHA_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bsfc_pkg::REG_SPS:       sps_q       <= cfg_data_i[bsfc_pkg::SPS_W-1:0];
        bsfc_pkg::REG_BODY_LEN:  body_len_q  <= cfg_data_i[bsfc_pkg::LEN_W-1:0];
        bsfc_pkg::REG_FRAME_LEN: frame_len_q <= cfg_data_i[bsfc_pkg::LEN_W-1:0];
        bsfc_pkg::REG_CAPACITY:  capacity_q  <= cfg_data_i[bsfc_pkg::LEN_W-1:0];
        bsfc_pkg::REG_ON_FLOOR:  on_floor_q  <= cfg_data_i[bsfc_pkg::FLOOR_W-1:0];
        bsfc_pkg::REG_OFF_FLOOR: off_floor_q <= cfg_data_i[bsfc_pkg::FLOOR_W-1:0];
        bsfc_pkg::REG_ALPHA:     alpha_q     <= cfg_data_i[bsfc_pkg::ALPHA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Handshake: the sample in the input register moves on when the result
  // register is empty or is being drained this cycle.
  assign advance      = in_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready  = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      sample_q <= in_if.sample;
    end
  end

  // Magnitude, saturated so that the most negative sample maps to full scale.
  assign mag_full = sample_q[SAMPLE_BITS-1] ? (~sample_q + 1'b1) : sample_q;
  assign ax       = mag_full[SAMPLE_BITS-1] ? {AX_W{1'b1}} : mag_full[AX_W-1:0];

  bsfc_floor #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_floor (
    .ax_i        (ax),
    .noise_i     (noise_q),
    .alpha_i     (alpha_q),
    .on_floor_i  (on_floor_q),
    .off_floor_i (off_floor_q),
    .noise_o     (noise_upd),
    .flags_o     (flags)
  );

  // Effective capacity, clamped to 1 .. MAX_CAPTURE.
  assign cap_raw = CMP_W'(capacity_q);
  always_comb begin
    if (cap_raw == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_raw > CMP_W'(MAX_CAPTURE)) begin
      cap_eff = CMP_W'(MAX_CAPTURE);
    end else begin
      cap_eff = cap_raw;
    end
  end

  // Collecting step: buffer write, quiet run and end-of-burst checks.
  assign room        = CMP_W'(count_q) < cap_eff;
  assign count_inc   = room ? (count_q + 1'b1) : count_q;
  assign quiet_inc   = !flags.quiet ? '0 :
                       (quiet_q != bsfc_pkg::QUIET_MAX) ? (quiet_q + 1'b1) : quiet_q;
  assign silence_lim = SIL_W'(sps_q) * SIL_W'(bsfc_pkg::SILENCE_SYMBOLS);
  assign full_hit    = (CMP_W'(count_inc) >= CMP_W'(frame_len_q)) ||
                       (CMP_W'(count_inc) >= cap_eff);
  assign silence_hit = SIL_W'(quiet_inc) > silence_lim;

  // Next state and result for the sample in the input register.
  always_comb begin
    mode_d       = mode_q;
    noise_d      = noise_q;
    count_d      = count_q;
    quiet_d      = quiet_q;
    st_valid_d   = 1'b0;
    st_index_d   = '0;
    st_sample_d  = '0;
    fr_ready_d   = 1'b0;
    fr_samples_d = '0;
    if (!mode_q) begin
      noise_d = noise_upd;
      if (flags.trigger) begin
        mode_d      = 1'b1;
        quiet_d     = '0;
        count_d     = CNT_W'(1);
        st_valid_d  = 1'b1;
        st_sample_d = sample_q;
      end
    end else begin
      st_valid_d  = room;
      st_index_d  = room ? count_q[IDX_W-1:0] : '0;
      st_sample_d = room ? sample_q : '0;
      count_d     = count_inc;
      quiet_d     = quiet_inc;
      if (full_hit) begin
        fr_ready_d   = 1'b1;
        fr_samples_d = count_inc;
        mode_d       = 1'b0;
        count_d      = '0;
        quiet_d      = '0;
      end else if (silence_hit) begin
        if (CMP_W'(count_inc) >= CMP_W'(body_len_q)) begin
          fr_ready_d   = 1'b1;
          fr_samples_d = count_inc;
        end
        mode_d  = 1'b0;
        count_d = '0;
        quiet_d = '0;
      end
    end
  end

  // State registers, updated once per sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      noise_q <= '0;
      count_q <= '0;
      quiet_q <= '0;
    end else if (advance) begin
      mode_q  <= mode_d;
      noise_q <= noise_d;
      count_q <= count_d;
      quiet_q <= quiet_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      st_valid_q   <= st_valid_d;
      st_index_q   <= st_index_d;
      st_sample_q  <= st_sample_d;
      fr_ready_q   <= fr_ready_d;
      fr_samples_q <= fr_samples_d;
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.store_valid   = st_valid_q;
  assign out_if.store_index   = st_index_q;
  assign out_if.stored_sample = st_sample_q;
  assign out_if.frame_ready   = fr_ready_q;
  assign out_if.frame_samples = fr_samples_q;
  assign out_if.collecting    = mode_q;

`ifndef SYNTHESIS
  // While searching, both counters stay cleared.
  a_search_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mode_q |-> (count_q == '0) && (quiet_q == '0))
    else $error("counters not cleared while searching");

  // A decode request always ends the burst.
  a_ready_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && fr_ready_q |-> !mode_q)
    else $error("decode request while still collecting");

  // A decode request never reports an empty capture.
  a_ready_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && fr_ready_q |-> (fr_samples_q != '0))
    else $error("decode request with zero samples");

  // Index zero is written only by the trigger sample, which starts collecting.
  a_trigger_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && st_valid_q && (st_index_q == '0) |-> mode_q)
    else $error("index zero written without entering collection");
`endif

endmodule : burst_squelch_frame_capture
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for burst_squelch_frame_capture
// Streams audio samples into the capture block under a series of register
// settings, predicts each result beat with a bit-exact squelch and capture
// predictor, and compares every field of every result beat in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned SB         = bsfc_pkg::SAMPLE_BITS_DEF;
  localparam int unsigned DEPTH      = bsfc_pkg::MAX_CAPTURE_DEF;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam longint      MAG_MAX    = (longint'(1) << (SB - 1)) - 1;
  localparam longint      Q16_ONE    = longint'(1) << bsfc_pkg::FRAC_BITS;
  localparam int          IDLE_PCT   = 34;
  localparam int          SETTLE     = 4;
  localparam int          HOLD_AT    = 300;
  localparam int          HOLD_LEN   = 64;

  typedef logic signed [SB-1:0] sample_t;

  // One result beat as the block reports it.
  typedef struct packed {
    logic             store_valid;
    logic [IDX_W-1:0] store_index;
    sample_t          stored_sample;
    logic             frame_ready;
    logic [CNT_W-1:0] frame_samples;
    logic             collecting;
  } capture_beat_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we;
  logic [bsfc_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [bsfc_pkg::CFG_W-1:0]     cfg_data;

  bsfc_in_if  in_ch ();
  bsfc_out_if out_ch ();

  burst_squelch_frame_capture DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Register copies and squelch state of the predictor.
  logic [bsfc_pkg::SPS_W-1:0]   sps_cfg;
  logic [bsfc_pkg::LEN_W-1:0]   body_cfg;
  logic [bsfc_pkg::LEN_W-1:0]   frame_cfg;
  logic [bsfc_pkg::LEN_W-1:0]   capacity_cfg;
  logic [bsfc_pkg::FLOOR_W-1:0] on_cfg;
  logic [bsfc_pkg::FLOOR_W-1:0] off_cfg;
  logic [bsfc_pkg::ALPHA_W-1:0] alpha_cfg;

  bit          collecting_st;
  longint      floor_q16;
  int unsigned fill_count;
  int unsigned silent_len;

  sample_t       sample_queue[$];
  capture_beat_t expected_beats[$];
  capture_beat_t want;
  int            fail_count = 0;
  bit            steady;
  int            hold_cnt;
  int            beats_seen;
  bit            hold_done;

  // Works out the result beat for one accepted sample and advances the state.
  function automatic capture_beat_t capture_step(input sample_t smp);
    capture_beat_t r;
    longint        mag;
    longint        mag_q16;
    longint        trig_lvl;
    longint        quiet_lvl;
    int unsigned   eff_cap;
    r = '0;
    mag = (smp < 0) ? -longint'(smp) : longint'(smp);
    if (mag > MAG_MAX) mag = MAG_MAX;
    mag_q16 = mag * Q16_ONE;

    // Thresholds use the floor from before this sample.
    trig_lvl = longint'(bsfc_pkg::ON_MULT) * floor_q16;
    if (trig_lvl < longint'(on_cfg) * Q16_ONE) trig_lvl = longint'(on_cfg) * Q16_ONE;
    quiet_lvl = longint'(bsfc_pkg::OFF_MULT) * floor_q16;
    if (quiet_lvl < longint'(off_cfg) * Q16_ONE) quiet_lvl = longint'(off_cfg) * Q16_ONE;

    eff_cap = capacity_cfg;
    if (eff_cap == 0) eff_cap = 1;
    if (eff_cap > DEPTH) eff_cap = DEPTH;

    if (!collecting_st) begin
      floor_q16 = floor_q16 +
                  (((mag_q16 - floor_q16) * longint'(alpha_cfg)) >>> bsfc_pkg::FRAC_BITS);
      if (mag_q16 > trig_lvl) begin
        collecting_st   = 1'b1;
        silent_len      = 0;
        r.store_valid   = 1'b1;
        r.store_index   = '0;
        r.stored_sample = smp;
        fill_count      = 1;
      end
    end else begin
      if (fill_count < eff_cap) begin
        r.store_valid   = 1'b1;
        r.store_index   = fill_count[IDX_W-1:0];
        r.stored_sample = smp;
        fill_count++;
      end
      if (mag_q16 < quiet_lvl) begin
        if (silent_len < bsfc_pkg::QUIET_MAX) silent_len++;
      end else begin
        silent_len = 0;
      end
      // A full frame or buffer forces a request; a long silence ends the burst.
      if (fill_count >= frame_cfg || fill_count >= eff_cap) begin
        r.frame_ready   = 1'b1;
        r.frame_samples = fill_count[CNT_W-1:0];
        collecting_st   = 1'b0;
        fill_count      = 0;
        silent_len      = 0;
      end else if (silent_len > bsfc_pkg::SILENCE_SYMBOLS * sps_cfg) begin
        if (fill_count >= body_cfg) begin
          r.frame_ready   = 1'b1;
          r.frame_samples = fill_count[CNT_W-1:0];
        end
        collecting_st = 1'b0;
        fill_count    = 0;
        silent_len    = 0;
      end
    end
    r.collecting = collecting_st;
    return r;
  endfunction

  // Sample driver: predicts each accepted beat and offers the next sample.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid  <= 1'b0;
      in_ch.sample <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_beats.push_back(capture_step(in_ch.sample));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (sample_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          in_ch.valid  <= 1'b1;
          in_ch.sample <= sample_queue.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each beat against the oldest expectation and
  // throttles ready, once holding it low long enough to back up the input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      hold_cnt     <= 0;
      beats_seen   <= 0;
      hold_done    <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        beats_seen <= beats_seen + 1;
        if (expected_beats.size() == 0) begin
          $error("result beat with no sample pending");
          fail_count++;
        end else begin
          want = expected_beats.pop_front();
          if (out_ch.store_valid !== want.store_valid) begin
            $error("store_valid: expected %0d, got %0d", want.store_valid,
                   out_ch.store_valid);
            fail_count++;
          end
          if (out_ch.store_index !== want.store_index) begin
            $error("store_index: expected %0d, got %0d", want.store_index,
                   out_ch.store_index);
            fail_count++;
          end
          if (out_ch.stored_sample !== want.stored_sample) begin
            $error("stored_sample: expected %0d, got %0d", want.stored_sample,
                   out_ch.stored_sample);
            fail_count++;
          end
          if (out_ch.frame_ready !== want.frame_ready) begin
            $error("frame_ready: expected %0d, got %0d", want.frame_ready,
                   out_ch.frame_ready);
            fail_count++;
          end
          if (out_ch.frame_samples !== want.frame_samples) begin
            $error("frame_samples: expected %0d, got %0d", want.frame_samples,
                   out_ch.frame_samples);
            fail_count++;
          end
          if (out_ch.collecting !== want.collecting) begin
            $error("collecting: expected %0d, got %0d", want.collecting,
                   out_ch.collecting);
            fail_count++;
          end
        end
      end
      if (hold_cnt != 0) begin
        hold_cnt     <= hold_cnt - 1;
        out_ch.ready <= 1'b0;
      end else if (beats_seen >= HOLD_AT && !hold_done) begin
        hold_cnt     <= HOLD_LEN;
        hold_done    <= 1'b1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Waits until every sample went in and every result came back.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (sample_queue.size() != 0 || in_ch.valid || expected_beats.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [bsfc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bsfc_pkg::CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      bsfc_pkg::REG_SPS:       sps_cfg      = val[bsfc_pkg::SPS_W-1:0];
      bsfc_pkg::REG_BODY_LEN:  body_cfg     = val[bsfc_pkg::LEN_W-1:0];
      bsfc_pkg::REG_FRAME_LEN: frame_cfg    = val[bsfc_pkg::LEN_W-1:0];
      bsfc_pkg::REG_CAPACITY:  capacity_cfg = val[bsfc_pkg::LEN_W-1:0];
      bsfc_pkg::REG_ON_FLOOR:  on_cfg       = val[bsfc_pkg::FLOOR_W-1:0];
      bsfc_pkg::REG_OFF_FLOOR: off_cfg      = val[bsfc_pkg::FLOOR_W-1:0];
      bsfc_pkg::REG_ALPHA:     alpha_cfg    = val[bsfc_pkg::ALPHA_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input int sps, input int body, input int frame, input int cap,
                              input int on_lvl, input int off_lvl, input int alpha);
    write_reg(bsfc_pkg::REG_SPS, bsfc_pkg::CFG_W'(sps));
    write_reg(bsfc_pkg::REG_BODY_LEN, bsfc_pkg::CFG_W'(body));
    write_reg(bsfc_pkg::REG_FRAME_LEN, bsfc_pkg::CFG_W'(frame));
    write_reg(bsfc_pkg::REG_CAPACITY, bsfc_pkg::CFG_W'(cap));
    write_reg(bsfc_pkg::REG_ON_FLOOR, bsfc_pkg::CFG_W'(on_lvl));
    write_reg(bsfc_pkg::REG_OFF_FLOOR, bsfc_pkg::CFG_W'(off_lvl));
    write_reg(bsfc_pkg::REG_ALPHA, bsfc_pkg::CFG_W'(alpha));
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Pushes n samples spread evenly over -amp .. amp.
  task automatic push_noise(input int n, input int amp);
    for (int i = 0; i < n; i++) begin
      sample_queue.push_back(sample_t'(int'($urandom_range(2 * amp)) - amp));
    end
  endtask

  // Mostly well-formed bursts (floor noise, a loud onset, a loud body and a
  // quiet tail) with random lengths, mixed with raw full-range samples.
  task automatic random_traffic(input int n_items, input int body_max, input int tail_max,
                                input int tail_amp);
    int start;
    int mag;
    start = sample_queue.size();
    while (sample_queue.size() - start < n_items) begin
      if ($urandom_range(9) < 2) begin
        repeat ($urandom_range(8, 1)) sample_queue.push_back(sample_t'($urandom));
      end else begin
        push_noise($urandom_range(5), 300);
        if ($urandom_range(15) == 0) begin
          sample_queue.push_back(sample_t'(-32768));
        end else begin
          mag = $urandom_range(32767, 2000);
          sample_queue.push_back(sample_t'($urandom_range(1) ? -mag : mag));
        end
        for (int i = $urandom_range(body_max); i > 0; i--) begin
          mag = ($urandom_range(7) == 0) ? $urandom_range(200) : $urandom_range(32767);
          sample_queue.push_back(sample_t'($urandom_range(1) ? -mag : mag));
        end
        push_noise($urandom_range(tail_max), $urandom_range(tail_amp));
      end
    end
  endtask

  // Stimulus: phases of register settings, each drained before the next.
  initial begin
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
    steady       = 1'b0;
    sps_cfg      = bsfc_pkg::SPS_RST;
    body_cfg     = bsfc_pkg::BODY_LEN_RST;
    frame_cfg    = bsfc_pkg::FRAME_LEN_RST;
    capacity_cfg = bsfc_pkg::CAPACITY_RST;
    on_cfg       = bsfc_pkg::ON_FLOOR_RST;
    off_cfg      = bsfc_pkg::OFF_FLOOR_RST;
    alpha_cfg    = bsfc_pkg::ALPHA_RST;
    collecting_st = 1'b0;
    floor_q16    = 0;
    fill_count   = 0;
    silent_len   = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: floor tracking, then a long capture that stays open.
    push_noise(60, 500);
    sample_queue.push_back(sample_t'(20000));
    repeat (80) sample_queue.push_back(sample_t'($urandom));
    wait_idle();

    // Directed: sample extremes, sub-threshold levels, trigger on the most
    // negative value, buffer full, silence end and a capture that ends short.
    apply_config(1, 3, 8, 6, 655, 328, 66);
    push_noise(5, 0);
    sample_queue.push_back(sample_t'(1));
    sample_queue.push_back(sample_t'(-1));
    sample_queue.push_back(sample_t'(600));
    sample_queue.push_back(sample_t'(-600));
    sample_queue.push_back(sample_t'(-32768));
    sample_queue.push_back(sample_t'(32767));
    sample_queue.push_back(sample_t'(-32767));
    push_noise(4, 0);
    sample_queue.push_back(sample_t'(20000));
    sample_queue.push_back(sample_t'(100));
    push_noise(4, 0);
    sample_queue.push_back(sample_t'(-25000));
    push_noise(4, 0);
    wait_idle();

    // Short frames with a fast floor; the long receiver hold lands here.
    apply_config(2, 10, 40, 30, 655, 328, 4000);
    random_traffic(350, 45, 12, 300);
    wait_idle();

    // Everything at zero: capacity clamps to one, frame length zero ends each
    // burst on the sample after its trigger, any burst is accepted, floor frozen.
    apply_config(0, 0, 0, 0, 0, 0, 0);
    random_traffic(120, 4, 4, 100);
    wait_idle();

    // Upper extremes written with out-of-range bits: trigger impossible,
    // capacity clamped to the buffer size, fastest floor.
    apply_config(19'h7FFFF, 19'h7FFFF, 50, 19'h7FFFF, 19'h7FFFF, 32767, 65535);
    random_traffic(80, 5, 5, 300);
    wait_idle();

    // Floor follows each magnitude; high quiet level drops most bursts.
    apply_config(3, 20, 60, DEPTH, 2000, 8000, 65535);
    random_traffic(280, 70, 15, 7000);
    wait_idle();

    // Silence limit at the quiet counter's ceiling: a long quiet run never
    // ends the capture, which only ends on the frame length.
    apply_config(5461, 1, 150, 160, 655, 1000, 65535);
    steady <= 1'b1;
    push_noise(20, 0);
    sample_queue.push_back(sample_t'(32767));
    push_noise(160, 0);
    wait_idle();

    // Typical settings with no idling on either side.
    apply_config(4, 16, 100, 64, 655, 328, 66);
    random_traffic(380, 80, 16, 250);
    wait_idle();

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule : testbench
